// ----- src/assert_macros.svh -----
// Assertion macros shared by the bounding box RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check
`define OBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle
`define OBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/obb_pkg.sv -----
// Shared types, constants and helpers for the opaque bounding box block.
// No dependencies; imported by obb_tracker, obb_rect and the top level.
package obb_pkg;

    // Largest frame side; coordinate and size widths follow from it
    localparam int MAX_DIM  = 4096;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int BORDER_W = 12;
    localparam int CHAN_W   = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BORDER       = 2'd2,
        CFG_ZERO_ALPHA   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [BORDER_W-1:0] border;
        logic                zero_alpha;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_pixel;
    } t_pixel;

    // Final extent of one frame set, handed from tracker to rectangle stage
    typedef struct packed {
        logic [COORD_W-1:0] least_x;
        logic [COORD_W-1:0] least_y;
        logic [COORD_W-1:0] greatest_x;
        logic [COORD_W-1:0] greatest_y;
        logic               seen;
    } t_box;

    // Handshake between tracker and rectangle stage
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    // Force a frame side into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

// ----- src/opaque_bounding_box.sv -----
// Top level of the opaque bounding box block: ports, config registers, input register.
// Depends on obb_pkg, obb_tracker, obb_rect and assert_macros.svh.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | one RGBA pixel in raster order; tlast on final pixel of set
//  m_axis   | out       | bordered rectangle of the set; tuser set when nothing opaque
//  cfg      | in        | register write: frame_width, frame_height, border, zero_alpha
//
// One pixel is accepted per cycle; pixels are never stalled except by a waiting result.
// From the last pixel to its result beat the path runs through the input register,
// tracker extent register, result register. Reset (synchronous, active low) clears
// counters and extent and sets frame size 4096 x 4096, border 0, zero alpha off.
// A stalled result blocks only the next last pixel; ordinary pixels keep flowing.
`include "assert_macros.svh"

module opaque_bounding_box
    import obb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic [31:0]           i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // rect_x[11:0], rect_y[23:12], rect_width[36:24], rect_height[49:37], zero pad
    output logic [55:0]           o_m_axis_tdata,
    // empty_res[0]
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_addr,
    input  logic [DIM_W-1:0]      i_cfg_wdata
);

    t_cfg   r_cfg;
    logic   r_s0_v;
    t_pixel r_s0_px;

    logic               px_take;
    logic               s_take;
    t_hs                box_fwd, box_back;
    t_box               box;
    logic [COORD_W-1:0] rect_x, rect_y;
    logic [DIM_W-1:0]   rect_w, rect_h;
    logic               rect_empty;
    t_cfg_idx           cfg_idx;

    assign cfg_idx = t_cfg_idx'(i_cfg_addr);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= DIM_W'(MAX_DIM);
            r_cfg.frame_height <= DIM_W'(MAX_DIM);
            r_cfg.border       <= '0;
            r_cfg.zero_alpha   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (cfg_idx)
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_wdata;
                CFG_BORDER:       r_cfg.border       <= i_cfg_wdata[BORDER_W-1:0];
                CFG_ZERO_ALPHA:   r_cfg.zero_alpha   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register: refill when empty or when the tracker takes the held pixel
    assign o_s_axis_tready = !r_s0_v || px_take;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s0_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_s0_px.red        <= i_s_axis_tdata[7:0];
            r_s0_px.green      <= i_s_axis_tdata[15:8];
            r_s0_px.blue       <= i_s_axis_tdata[23:16];
            r_s0_px.alpha      <= i_s_axis_tdata[31:24];
            r_s0_px.last_pixel <= i_s_axis_tlast;
        end
    end

    obb_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_px_valid    (r_s0_v),
        .i_px          (r_s0_px),
        .o_px_take     (px_take),
        .o_box_hs_fwd  (box_fwd),
        .i_box_hs_back (box_back),
        .o_box         (box)
    );

    obb_rect u_rect (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_box_hs_fwd  (box_fwd),
        .o_box_hs_back (box_back),
        .i_box         (box),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_rect_x      (rect_x),
        .o_rect_y      (rect_y),
        .o_rect_width  (rect_w),
        .o_rect_height (rect_h),
        .o_empty       (rect_empty)
    );

    assign o_m_axis_tdata = {6'd0, rect_h, rect_w, rect_y, rect_x};
    assign o_m_axis_tuser = rect_empty;

    `OBB_ASSERT_NEXT(a_s0_held, r_s0_v && !px_take,
        r_s0_v && $stable(r_s0_px), "held pixel overwritten before use")
    `OBB_ASSERT_IMP(a_take_needs_pixel, px_take, r_s0_v,
        "tracker took a pixel from an empty input register")

endmodule

// ----- src/obb_tracker.sv -----
// Position counters and opaque extent tracking for the bounding box block.
// Depends on obb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module obb_tracker
    import obb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_px_valid,
    input  t_pixel i_px,
    output logic   o_px_take,
    output t_hs    o_box_hs_fwd,
    input  t_hs    i_box_hs_back,
    output t_box   o_box
);

    logic [COORD_W-1:0] r_column, r_row;
    logic [COORD_W-1:0] r_least_x, r_least_y, r_greatest_x, r_greatest_y;
    logic               r_seen;
    logic               r_fin_v;
    t_box               r_fin;

    logic [DIM_W-1:0]   fw, fh, col_inc, row_inc;
    logic               transparent, opaque, fin_free;
    t_box               n_box;

    // Classify the pixel and fold its position into the extent
    always_comb begin
        fw          = clamp_dim(i_cfg.frame_width);
        fh          = clamp_dim(i_cfg.frame_height);
        transparent = ((i_px.red == '0) && (i_px.green == '0) &&
                       (i_px.blue == '0) && (i_px.alpha == '0)) ||
                      (i_cfg.zero_alpha && (i_px.alpha == '0));
        opaque      = !transparent;
        n_box.least_x    = (opaque && (r_column < r_least_x)) ? r_column : r_least_x;
        n_box.least_y    = (opaque && (r_row < r_least_y)) ? r_row : r_least_y;
        n_box.greatest_x = (opaque && (r_column > r_greatest_x)) ? r_column : r_greatest_x;
        n_box.greatest_y = (opaque && (r_row > r_greatest_y)) ? r_row : r_greatest_y;
        n_box.seen       = r_seen | opaque;
        col_inc     = {1'b0, r_column} + DIM_W'(1);
        row_inc     = {1'b0, r_row} + DIM_W'(1);
        fin_free    = !r_fin_v || i_box_hs_back.ready;
        o_px_take   = i_px_valid && (!i_px.last_pixel || fin_free);
    end

    // Advance counters and extent; clear them after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_row        <= '0;
            r_least_x    <= '1;
            r_least_y    <= '1;
            r_greatest_x <= '0;
            r_greatest_y <= '0;
            r_seen       <= 1'b0;
            r_fin_v      <= 1'b0;
        end else begin
            if (r_fin_v && i_box_hs_back.ready) begin
                r_fin_v <= 1'b0;
            end
            if (o_px_take) begin
                if (i_px.last_pixel) begin
                    r_column     <= '0;
                    r_row        <= '0;
                    r_least_x    <= '1;
                    r_least_y    <= '1;
                    r_greatest_x <= '0;
                    r_greatest_y <= '0;
                    r_seen       <= 1'b0;
                    r_fin_v      <= 1'b1;
                end else begin
                    r_least_x    <= n_box.least_x;
                    r_least_y    <= n_box.least_y;
                    r_greatest_x <= n_box.greatest_x;
                    r_greatest_y <= n_box.greatest_y;
                    r_seen       <= n_box.seen;
                    if (col_inc >= fw) begin
                        r_column <= '0;
                        r_row    <= (row_inc >= fh) ? '0 : row_inc[COORD_W-1:0];
                    end else begin
                        r_column <= col_inc[COORD_W-1:0];
                    end
                end
            end
        end
    end

    // Hold the final extent for the rectangle stage
    always_ff @(posedge i_clk) begin
        if (o_px_take && i_px.last_pixel) begin
            r_fin <= n_box;
        end
    end

    assign o_box_hs_fwd.valid = r_fin_v;
    assign o_box_hs_fwd.ready = fin_free;
    assign o_box              = r_fin;

    `OBB_ASSERT_NEXT(a_clear_after_last, o_px_take && i_px.last_pixel,
        (r_column == '0) && (r_row == '0) && !r_seen && r_fin_v,
        "tracking not cleared after last pixel")
    `OBB_ASSERT_NEXT(a_fin_held, r_fin_v && !i_box_hs_back.ready,
        r_fin_v && $stable(r_fin), "final extent lost while stalled")

endmodule

// ----- src/obb_rect.sv -----
// Bordered rectangle computation and result register of the bounding box block.
// Depends on obb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module obb_rect
    import obb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_hs                i_box_hs_fwd,
    output t_hs                o_box_hs_back,
    input  t_box               i_box,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_rect_x,
    output logic [COORD_W-1:0] o_rect_y,
    output logic [DIM_W-1:0]   o_rect_width,
    output logic [DIM_W-1:0]   o_rect_height,
    output logic               o_empty
);

    logic               r_out_v;
    logic [COORD_W-1:0] r_x, r_y;
    logic [DIM_W-1:0]   r_w, r_h;
    logic               r_empty;

    logic               out_free;
    logic [COORD_W-1:0] n_x, n_y;
    logic [DIM_W-1:0]   n_w, n_h;

    // Origin clamped at zero, end clamped at the frame side
    function automatic logic [COORD_W+DIM_W-1:0] edge_span(
        input logic [COORD_W-1:0]  lo,
        input logic [COORD_W-1:0]  hi,
        input logic [BORDER_W-1:0] brd,
        input logic [DIM_W-1:0]    dim
    );
        logic [COORD_W-1:0] org;
        logic [DIM_W-1:0]   fin;
        logic [DIM_W-1:0]   sz;
        org = ({1'b0, lo} > {1'b0, brd}) ? COORD_W'({1'b0, lo} - {1'b0, brd}) : '0;
        fin = {1'b0, hi} + DIM_W'(1) + DIM_W'(brd);
        if (fin > dim) begin
            fin = dim;
        end
        sz = (fin > {1'b0, org}) ? (fin - {1'b0, org}) : '0;
        return {org, sz};
    endfunction

    // Build the rectangle from the final extent
    always_comb begin
        {n_x, n_w} = edge_span(i_box.least_x, i_box.greatest_x, i_cfg.border,
                               clamp_dim(i_cfg.frame_width));
        {n_y, n_h} = edge_span(i_box.least_y, i_box.greatest_y, i_cfg.border,
                               clamp_dim(i_cfg.frame_height));
        out_free   = !r_out_v || i_ready;
    end

    // Result valid advances whenever the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= i_box_hs_fwd.valid;
        end
    end

    // Load the result beat; empty set gives zeros
    always_ff @(posedge i_clk) begin
        if (out_free && i_box_hs_fwd.valid) begin
            r_empty <= !i_box.seen;
            r_x     <= i_box.seen ? n_x : '0;
            r_y     <= i_box.seen ? n_y : '0;
            r_w     <= i_box.seen ? n_w : '0;
            r_h     <= i_box.seen ? n_h : '0;
        end
    end

    assign o_box_hs_back.valid = r_out_v;
    assign o_box_hs_back.ready = out_free;
    assign o_valid             = r_out_v;
    assign o_rect_x            = r_x;
    assign o_rect_y            = r_y;
    assign o_rect_width        = r_w;
    assign o_rect_height       = r_h;
    assign o_empty             = r_empty;

    `OBB_ASSERT_IMP(a_empty_zero, r_out_v && r_empty,
        (r_x == '0) && (r_y == '0) && (r_w == '0) && (r_h == '0),
        "empty result carries a nonzero rectangle")
    `OBB_ASSERT_IMP(a_width_in_frame, r_out_v,
        r_w <= DIM_W'(MAX_DIM) && r_h <= DIM_W'(MAX_DIM),
        "rectangle larger than the largest frame")

endmodule

// ----- tb/tb_opaque_bounding_box.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for opaque_bounding_box: pixel streams with random gaps and stalls.
// Depends on obb_pkg and the opaque_bounding_box RTL; a local box tracker predicts each result.
module tb_opaque_bounding_box;
    import obb_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_RUN = 48;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic               empty;
    } t_rect_beat;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [31:0]       s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [55:0]       m_tdata;
    logic              m_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              cfg_wr_en = 1'b0;
    t_cfg_idx          cfg_addr = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]  cfg_wdata = '0;

    // Box tracker: settings and running extent
    logic [DIM_W-1:0]    set_w;
    logic [DIM_W-1:0]    set_h;
    logic [BORDER_W-1:0] set_border;
    logic                set_za;
    int unsigned col_cnt, row_cnt, min_x, min_y, max_x, max_y;
    bit          seen_opaque;

    t_rect_beat rect_expect_q[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int pixels_sent = 0;
    int mismatches = 0;
    int stuck_cycles = 0;

    opaque_bounding_box uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
        return v;
    endfunction

    // Widen [lo, hi] by the border; clamp origin at zero and end at the frame side
    function automatic void bordered_span(int unsigned lo, int unsigned hi, int unsigned dim,
                                          output int unsigned origin,
                                          output int unsigned size);
        int unsigned stop;
        origin = (lo > set_border) ? lo - set_border : 0;
        stop = hi + 1 + set_border;
        if (stop > dim) stop = dim;
        size = (stop > origin) ? stop - origin : 0;
    endfunction

    function automatic void clear_extent();
        col_cnt = 0;
        row_cnt = 0;
        min_x = MAX_DIM - 1;
        min_y = MAX_DIM - 1;
        max_x = 0;
        max_y = 0;
        seen_opaque = 0;
    endfunction

    // Advance the tracker by one accepted pixel; queue the rectangle on the last one
    function automatic void track_pixel(logic [31:0] px, logic last);
        int unsigned fw, fh, x0, y0, w, h;
        logic        clear;
        t_rect_beat  beat;
        fw = eff_dim(set_w);
        fh = eff_dim(set_h);
        clear = (px == '0) || (set_za && px[31:24] == '0);
        if (!clear) begin
            if (col_cnt < min_x) min_x = col_cnt;
            if (row_cnt < min_y) min_y = row_cnt;
            if (col_cnt > max_x) max_x = col_cnt;
            if (row_cnt > max_y) max_y = row_cnt;
            seen_opaque = 1;
        end
        if (!last) begin
            if (col_cnt + 1 >= fw) begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1 >= fh) ? 0 : row_cnt + 1;
            end else begin
                col_cnt = col_cnt + 1;
            end
            return;
        end
        beat = '0;
        if (!seen_opaque) begin
            beat.empty = 1'b1;
        end else begin
            bordered_span(min_x, max_x, fw, x0, w);
            bordered_span(min_y, max_y, fh, y0, h);
            beat.x = x0[COORD_W-1:0];
            beat.y = y0[COORD_W-1:0];
            beat.w = w[DIM_W-1:0];
            beat.h = h[DIM_W-1:0];
        end
        rect_expect_q.push_back(beat);
        clear_extent();
    endfunction

    // Pixel generator: pixels drawn as opaque always carry nonzero alpha
    function automatic logic [31:0] pick_pixel(int opaque_pct);
        logic [31:0] px;
        px = $urandom;
        if ($urandom_range(99) < opaque_pct) px[31:24] = 8'($urandom_range(1, 255));
        else if ($urandom_range(1)) px = '0;
        else px[31:24] = '0;
        return px;
    endfunction

    // Send one pixel beat after a random gap; hold until accepted
    task automatic send_pixel(logic [31:0] px, logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        track_pixel(px, last);
        pixels_sent++;
    endtask

    // Drop valid, wait for every queued rectangle, then let the pipeline settle
    task automatic finish_traffic();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rect_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges
    task automatic load_settings(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                 logic [BORDER_W-1:0] brd, logic za);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= CFG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_addr  <= CFG_BORDER;
        cfg_wdata <= {1'b0, brd};
        @(posedge clk);
        cfg_addr  <= CFG_ZERO_ALPHA;
        cfg_wdata <= {{(DIM_W-1){1'b0}}, za};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        set_w      = w;
        set_h      = h;
        set_border = brd;
        set_za     = za;
    endtask

    task automatic set_pressure(int src_idle, int snk_stall);
        idle_pct  = src_idle;
        stall_pct = snk_stall;
    endtask

    // Default 4096 x 4096 frame: empty set, then a single opaque pixel at the origin
    task automatic test_reset_defaults();
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h0000_0001, 1'b1);
        finish_traffic();
    endtask

    // Channel extremes, zero-alpha mode, huge border, out-of-range sizes
    task automatic test_directed_pixels();
        load_settings(13'd4, 13'd3, 12'd0, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_00FF, 1'b0);
        send_pixel(32'h0000_FF00, 1'b0);
        send_pixel(32'h00FF_0000, 1'b0);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        finish_traffic();
        load_settings(13'd4, 13'd3, 12'd4095, 1'b1);
        send_pixel(32'h00FF_FFFF, 1'b0);
        send_pixel(32'h0100_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0001, 1'b1);
        finish_traffic();
        load_settings(13'd0, 13'd8191, 12'd1, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0080_0000, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        finish_traffic();
    endtask

    // Shrink the frame while the counters sit beyond the new size; end lands before origin
    task automatic test_size_change_mid_frame();
        load_settings(13'd8, 13'd8, 12'd0, 1'b0);
        repeat (13) send_pixel(32'h0000_0000, 1'b0);
        finish_traffic();
        load_settings(13'd3, 13'd1, 12'd0, 1'b0);
        send_pixel(32'h4000_0000, 1'b1);
        finish_traffic();
        load_settings(13'd8, 13'd8, 12'd0, 1'b0);
        repeat (20) send_pixel(pick_pixel(30), 1'b0);
        finish_traffic();
        load_settings(13'd2, 13'd2, 12'd1, 1'b1);
        repeat (6) send_pixel(pick_pixel(30), 1'b0);
        send_pixel(pick_pixel(30), 1'b1);
        finish_traffic();
    endtask

    // Oversized sides acting as full size: a long row with the end clamped at the
    // full frame width, then a long column; opaque at both ends of each run
    task automatic test_large_frames();
        int i;
        load_settings(13'd8191, 13'd0, 12'd4095, 1'b0);
        for (i = 0; i < LONG_RUN; i++)
            send_pixel(pick_pixel((i == 0 || i == LONG_RUN - 1) ? 100 : 2), i == LONG_RUN - 1);
        finish_traffic();
        load_settings(13'd0, 13'd5000, 12'd2, 1'b1);
        for (i = 0; i < LONG_RUN; i++)
            send_pixel(pick_pixel((i == 0 || i == LONG_RUN - 1) ? 100 : 2), i == LONG_RUN - 1);
        finish_traffic();
    endtask

    task automatic random_settings();
        logic [DIM_W-1:0]    w, h;
        logic [BORDER_W-1:0] brd;
        case ($urandom_range(9))
            0: w = '0;
            1: w = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            2: w = DIM_W'(MAX_DIM);
            default: w = DIM_W'($urandom_range(1, 10));
        endcase
        case ($urandom_range(9))
            0: h = '0;
            1: h = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            2: h = DIM_W'(MAX_DIM);
            default: h = DIM_W'($urandom_range(1, 10));
        endcase
        if ($urandom_range(4) == 0) brd = BORDER_W'($urandom_range(0, 4095));
        else brd = BORDER_W'($urandom_range(0, 3));
        load_settings(w, h, brd, 1'($urandom_range(1)));
    endtask

    // Frame sets of whole frames mostly, some cut short or left open across a size change
    task automatic test_random_sets(int n_items);
        int target, n, fpix, opq, i;
        logic with_last;
        target = pixels_sent + n_items;
        while (pixels_sent < target) begin
            if ($urandom_range(99) < 20) begin
                finish_traffic();
                random_settings();
            end
            fpix = eff_dim(set_w) * eff_dim(set_h);
            if ($urandom_range(3) != 0 && fpix <= 48) n = fpix * $urandom_range(1, 3);
            else n = $urandom_range(1, 40);
            case ($urandom_range(3))
                0: opq = 0;
                1: opq = 3;
                2: opq = 30;
                default: opq = 90;
            endcase
            with_last = ($urandom_range(99) < 88);
            for (i = 0; i < n; i++) send_pixel(pick_pixel(opq), with_last && i == n - 1);
        end
        finish_traffic();
    endtask

    // Receiver: random stalls, result check, watchdog
    always @(posedge clk) begin : rect_check
        t_rect_beat want;
        m_tready <= ($urandom_range(99) >= stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (rect_expect_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual data %h user %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = rect_expect_q.pop_front();
                if (m_tdata[11:0] !== want.x) begin
                    $display("%0t: rect_x expected %0d, actual %0d", $time, want.x,
                             m_tdata[11:0]);
                    mismatches++;
                end
                if (m_tdata[23:12] !== want.y) begin
                    $display("%0t: rect_y expected %0d, actual %0d", $time, want.y,
                             m_tdata[23:12]);
                    mismatches++;
                end
                if (m_tdata[36:24] !== want.w) begin
                    $display("%0t: rect_width expected %0d, actual %0d", $time, want.w,
                             m_tdata[36:24]);
                    mismatches++;
                end
                if (m_tdata[49:37] !== want.h) begin
                    $display("%0t: rect_height expected %0d, actual %0d", $time, want.h,
                             m_tdata[49:37]);
                    mismatches++;
                end
                if (m_tuser !== want.empty) begin
                    $display("%0t: empty_res expected %b, actual %b", $time, want.empty,
                             m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        set_w      = DIM_W'(MAX_DIM);
        set_h      = DIM_W'(MAX_DIM);
        set_border = '0;
        set_za     = 1'b0;
        clear_extent();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pressure(0, 0);
        test_reset_defaults();
        test_directed_pixels();
        test_size_change_mid_frame();
        test_large_frames();

        set_pressure(0, 0);
        test_random_sets(265);
        set_pressure(60, 0);
        test_random_sets(265);
        set_pressure(0, 60);
        test_random_sets(265);
        set_pressure(28, 28);
        test_random_sets(265);
        set_pressure(28, 28);
        test_size_change_mid_frame();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
